@@ hdl/sxfs_pkg.sv @@
// ----------------------------------------------------------------------------
// sxfs_pkg: shared types, constants and helpers of the sprite XOR frame store.
// Holds the controller/datapath command and status bundles, field widths and
// the wrap-around function used for screen coordinates.
// ----------------------------------------------------------------------------
package sxfs_pkg;

    // Default screen size in pixels.
    localparam int unsigned SCREEN_WIDTH_DEF  = 64;
    localparam int unsigned SCREEN_HEIGHT_DEF = 32;

    // Field widths of the input beat.
    localparam int unsigned ORIGIN_W = 8;
    localparam int unsigned ROW_IDX_W = 4;
    localparam int unsigned SPRITE_W = 8;
    localparam int unsigned BIT_IDX_W = 3;

    // Field widths of the output beat.
    localparam int unsigned PIX_X_W = 6;
    localparam int unsigned PIX_Y_W = 5;

    // Coordinate sums are at most 255 + 15, and the screen is at least eight
    // pixels on a side, so the quotient stays below 64: six trial subtracts.
    localparam int unsigned SUM_W      = ORIGIN_W + 1;
    localparam int unsigned WRAP_STEPS = 6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;   // capture the accepted input beat
        logic ram_rd;      // read the addressed screen row
        logic row_load;    // copy the read row into the working row
        logic bit_step;    // toggle the next set sprite bit and emit a result
        logic sweep_wr;    // write one zero row of the clearing sweep
        logic emit_single; // emit the single result of a clear or empty row
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_clear;    // the beat on the input is a clear operation
        logic in_empty;    // the beat on the input has no sprite bit set
        logic out_free;    // the output register can take a result this cycle
        logic last_bit;    // the bit being processed is the last set bit
        logic sweep_last;  // the clearing sweep is at its last row
    } t_status;

    // Value modulo a constant, by restoring trial subtraction.
    function automatic logic [SUM_W-1:0] wrap_mod(input logic [SUM_W-1:0] value,
                                                  input int unsigned modulus);
        logic [SUM_W-1:0] rem;
        rem = value;
        for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
            if (32'(rem) >= (modulus << k)) begin
                rem = rem - SUM_W'(modulus << k);
            end
        end
        return rem;
    endfunction

endpackage

@@ hdl/sxfs_ram.sv @@
// ----------------------------------------------------------------------------
// sxfs_ram: generic single-port RAM with registered read data.
// One access per cycle while i_en is high: a write when i_we is high, otherwise a read.
// ----------------------------------------------------------------------------
module sxfs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write or read one word.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/sxfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// sxfs_ctrl: controller of the sprite XOR frame store.
// Sequences the clearing sweep, the row read, the per-bit toggles and the
// single results of clear and empty rows.
// ----------------------------------------------------------------------------
module sxfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sxfs_pkg::t_status i_status,
    output sxfs_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_LOAD,
        S_BITS,
        S_CLEAR,
        S_SINGLE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   n_ready;
    logic   accept;

    assign accept     = i_in_valid && r_ready;
    assign o_in_ready = r_ready;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_ready = r_ready;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                    n_ready = 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_item = 1'b1;
                    n_ready         = 1'b0;
                    if (i_status.in_clear) begin
                        n_state = S_CLEAR;
                    end else if (i_status.in_empty) begin
                        n_state = S_SINGLE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.ram_rd = 1'b1;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.row_load = 1'b1;
                n_state        = S_BITS;
            end
            S_BITS: begin
                if (i_status.out_free) begin
                    o_cmd.bit_step = 1'b1;
                    if (i_status.last_bit) begin
                        n_state = S_IDLE;
                        n_ready = 1'b1;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_SINGLE;
                end
            end
            S_SINGLE: begin
                if (i_status.out_free) begin
                    o_cmd.emit_single = 1'b1;
                    n_state           = S_IDLE;
                    n_ready           = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_ready = 1'b1;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    // Ready is only offered between items.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_state == S_IDLE))
        else $error("ready outside idle state");

    // An accepted beat closes the input until its work is done.
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !r_ready)
        else $error("input still open after accept");

    // The last bit of a row returns the block to idle.
    a_last_bit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BITS && i_status.out_free && i_status.last_bit) |=> r_ready)
        else $error("row not finished after last bit");

endmodule

@@ hdl/sxfs_dpath.sv @@
// ----------------------------------------------------------------------------
// sxfs_dpath: datapath of the sprite XOR frame store.
// Holds the current item, the working screen row, the collision flag, the
// sweep counter and the output register, and drives the frame RAM port.
// ----------------------------------------------------------------------------
module sxfs_dpath #(
    parameter int unsigned SCREEN_WIDTH  = sxfs_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = sxfs_pkg::SCREEN_HEIGHT_DEF,
    localparam int unsigned XW = $clog2(SCREEN_WIDTH),
    localparam int unsigned YW = $clog2(SCREEN_HEIGHT)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sxfs_pkg::t_cmd                     i_cmd,
    output sxfs_pkg::t_status                  o_status,
    // Input fields.
    input  logic                               i_operation,
    input  logic [sxfs_pkg::ORIGIN_W-1:0]      i_origin_x,
    input  logic [sxfs_pkg::ORIGIN_W-1:0]      i_origin_y,
    input  logic [sxfs_pkg::ROW_IDX_W-1:0]     i_row_index,
    input  logic [sxfs_pkg::SPRITE_W-1:0]      i_sprite_row,
    input  logic                               i_first_row,
    input  logic                               i_last_row,
    // Output register.
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_pixel_valid,
    output logic [sxfs_pkg::PIX_X_W-1:0]       o_pixel_x,
    output logic [sxfs_pkg::PIX_Y_W-1:0]       o_pixel_y,
    output logic                               o_pixel_value,
    output logic                               o_collision,
    output logic                               o_run_last,
    output logic                               o_sprite_done,
    // Frame RAM port.
    output logic                               o_ram_en,
    output logic                               o_ram_we,
    output logic [YW-1:0]                      o_ram_addr,
    output logic [SCREEN_WIDTH-1:0]            o_ram_wdata,
    input  logic [SCREEN_WIDTH-1:0]            i_ram_rdata
);

    // Current item.
    logic                              r_op;
    logic [sxfs_pkg::ORIGIN_W-1:0]     r_ox;
    logic [YW-1:0]                     r_py;
    logic [sxfs_pkg::SPRITE_W-1:0]     r_bits;
    logic                              r_last;
    logic [SCREEN_WIDTH-1:0]           r_row;
    logic                              r_coll;
    logic [YW-1:0]                     r_sweep;

    // Output register.
    logic                              r_out_valid;
    logic                              r_o_pix;
    logic [sxfs_pkg::PIX_X_W-1:0]      r_o_x;
    logic [sxfs_pkg::PIX_Y_W-1:0]      r_o_y;
    logic                              r_o_val;
    logic                              r_o_coll;
    logic                              r_o_last;
    logic                              r_o_done;

    logic [sxfs_pkg::SUM_W-1:0]        y_sum;
    logic [YW-1:0]                     n_py;
    logic [sxfs_pkg::SPRITE_W-1:0]     top_bit;
    logic [sxfs_pkg::BIT_IDX_W-1:0]    col;
    logic [sxfs_pkg::SUM_W-1:0]        x_sum;
    logic [XW-1:0]                     px;
    logic                              prev;
    logic [SCREEN_WIDTH-1:0]           n_row;
    logic [sxfs_pkg::SPRITE_W-1:0]     n_bits;
    logic                              sweep_last;
    logic                              out_free;

    // Wrapped row of the accepted beat.
    assign y_sum = sxfs_pkg::SUM_W'(i_origin_y) + sxfs_pkg::SUM_W'(i_row_index);
    assign n_py  = YW'(sxfs_pkg::wrap_mod(y_sum, SCREEN_HEIGHT));

    // Leftmost remaining sprite bit and its wrapped column.
    always_comb begin
        top_bit = '0;
        col     = '0;
        for (int b = 0; b < sxfs_pkg::SPRITE_W; b++) begin
            if (r_bits[b]) begin
                top_bit = sxfs_pkg::SPRITE_W'(1) << b;
                col     = sxfs_pkg::BIT_IDX_W'(sxfs_pkg::SPRITE_W - 1 - b);
            end
        end
    end

    assign x_sum  = sxfs_pkg::SUM_W'(r_ox) + sxfs_pkg::SUM_W'(col);
    assign px     = XW'(sxfs_pkg::wrap_mod(x_sum, SCREEN_WIDTH));
    assign prev   = r_row[px];
    assign n_bits = r_bits & ~top_bit;

    // Working row with the current pixel toggled.
    always_comb begin
        n_row     = r_row;
        n_row[px] = ~prev;
    end

    assign sweep_last = (r_sweep == YW'(SCREEN_HEIGHT - 1));
    assign out_free   = !r_out_valid || i_out_ready;

    // Status to the controller.
    always_comb begin
        o_status            = '0;
        o_status.in_clear   = i_operation;
        o_status.in_empty   = (i_sprite_row == '0);
        o_status.out_free   = out_free;
        o_status.last_bit   = (n_bits == '0);
        o_status.sweep_last = sweep_last;
    end

    // Frame RAM port: sweep writes zero rows, the last bit writes the row back.
    assign o_ram_we    = i_cmd.sweep_wr || (i_cmd.bit_step && (n_bits == '0));
    assign o_ram_en    = o_ram_we || i_cmd.ram_rd;
    assign o_ram_addr  = i_cmd.sweep_wr ? r_sweep : r_py;
    assign o_ram_wdata = i_cmd.sweep_wr ? '0 : n_row;

    // Item payload and working row.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= i_operation;
            r_ox   <= i_origin_x;
            r_py   <= n_py;
            r_bits <= i_sprite_row;
            r_last <= i_last_row;
        end else if (i_cmd.bit_step) begin
            r_bits <= n_bits;
        end
        if (i_cmd.row_load) begin
            r_row <= i_ram_rdata;
        end else if (i_cmd.bit_step) begin
            r_row <= n_row;
        end
    end

    // Collision flag and sweep counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coll  <= 1'b0;
            r_sweep <= '0;
        end else begin
            if (i_cmd.load_item && !i_operation && i_first_row) begin
                r_coll <= 1'b0;
            end else if (i_cmd.bit_step) begin
                r_coll <= r_coll | prev;
            end
            if (i_cmd.sweep_wr) begin
                r_sweep <= sweep_last ? '0 : r_sweep + YW'(1);
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.bit_step || i_cmd.emit_single) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.bit_step) begin
            r_o_pix  <= 1'b1;
            r_o_x    <= sxfs_pkg::PIX_X_W'(px);
            r_o_y    <= sxfs_pkg::PIX_Y_W'(r_py);
            r_o_val  <= ~prev;
            r_o_coll <= r_coll | prev;
            r_o_last <= (n_bits == '0);
            r_o_done <= (n_bits == '0) && r_last;
        end else if (i_cmd.emit_single) begin
            r_o_pix  <= 1'b0;
            r_o_x    <= '0;
            r_o_y    <= '0;
            r_o_val  <= 1'b0;
            r_o_coll <= r_coll;
            r_o_last <= 1'b1;
            r_o_done <= !r_op && r_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_valid = r_o_pix;
    assign o_pixel_x     = r_o_x;
    assign o_pixel_y     = r_o_y;
    assign o_pixel_value = r_o_val;
    assign o_collision   = r_o_coll;
    assign o_run_last    = r_o_last;
    assign o_sprite_done = r_o_done;

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.bit_step || i_cmd.emit_single) |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten");

    // A bit step always has a sprite bit left to draw.
    a_bits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.bit_step |-> (r_bits != '0))
        else $error("bit step with no bit left");

    // The sweep counter stays on the screen.
    a_sweep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep <= YW'(SCREEN_HEIGHT - 1))
        else $error("sweep address off screen");

endmodule

@@ hdl/sprite_xor_frame_store_top.sv @@
// ----------------------------------------------------------------------------
// sprite_xor_frame_store_top: monochrome XOR frame store for a CHIP-8 display.
// Draws sprite rows by XOR into a row-wide frame RAM, reports each toggled
// pixel with a running collision flag, and clears the screen on request.
//
// Channel    Dir  Beat carries
// s_axis     in   tuser: operation; tlast: last_row; tdata: origin, row, bits
// m_axis     out  tuser: pixel_valid; tlast: run_last; tdata: pixel report
//
// A draw reads its row once through the single frame RAM port, then toggles
// one set sprite bit per cycle while the output register is free, with the row
// written back on the last one. An empty row gives a single result. A clear
// writes one zero row per cycle, then gives a single result. After reset the
// same sweep runs before s_axis_tready rises. A stall on m_axis holds the
// item's progress until the beat is taken.
// ----------------------------------------------------------------------------
module sprite_xor_frame_store_top #(
    parameter int unsigned SCREEN_WIDTH  = sxfs_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = sxfs_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // origin_x[7:0], origin_y[15:8], row_index[19:16], sprite_row[27:20],
    // first_row[28], zero[31:29]
    input  logic [31:0] s_axis_tdata,
    // operation[0]
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_x[5:0], pixel_y[10:6], pixel_value[11], collision[12],
    // sprite_done[13], zero[15:14]
    output logic [15:0] m_axis_tdata,
    // pixel_valid[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int unsigned YW = $clog2(SCREEN_HEIGHT);

    sxfs_pkg::t_cmd                cmd;
    sxfs_pkg::t_status             status;
    logic                          ram_en;
    logic                          ram_we;
    logic [YW-1:0]                 ram_addr;
    logic [SCREEN_WIDTH-1:0]       ram_wdata;
    logic [SCREEN_WIDTH-1:0]       ram_rdata;
    logic [sxfs_pkg::PIX_X_W-1:0]  pixel_x;
    logic [sxfs_pkg::PIX_Y_W-1:0]  pixel_y;
    logic                          pixel_value;
    logic                          collision;
    logic                          sprite_done;

    // Sequencer.
    sxfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Item registers, working row and output register.
    sxfs_dpath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_operation   (s_axis_tuser),
        .i_origin_x    (s_axis_tdata[7:0]),
        .i_origin_y    (s_axis_tdata[15:8]),
        .i_row_index   (s_axis_tdata[19:16]),
        .i_sprite_row  (s_axis_tdata[27:20]),
        .i_first_row   (s_axis_tdata[28]),
        .i_last_row    (s_axis_tlast),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_pixel_valid (m_axis_tuser),
        .o_pixel_x     (pixel_x),
        .o_pixel_y     (pixel_y),
        .o_pixel_value (pixel_value),
        .o_collision   (collision),
        .o_run_last    (m_axis_tlast),
        .o_sprite_done (sprite_done),
        .o_ram_en      (ram_en),
        .o_ram_we      (ram_we),
        .o_ram_addr    (ram_addr),
        .o_ram_wdata   (ram_wdata),
        .i_ram_rdata   (ram_rdata)
    );

    // Frame store, one screen row per word.
    sxfs_ram #(
        .WIDTH (SCREEN_WIDTH),
        .DEPTH (SCREEN_HEIGHT)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Pack the pixel report.
    assign m_axis_tdata = {2'b00, sprite_done, collision, pixel_value, pixel_y, pixel_x};

endmodule

@@ tb/sprite_xor_frame_store_top_tb.sv @@
// ----------------------------------------------------------------------------
// sprite_xor_frame_store_top_tb: self-checking bench for the sprite XOR store.
// A short table of directed beats is followed by random sprites, loose noise
// rows and screen clears. Every accepted input beat runs through a local copy
// of the frame and the collision flag, which predicts the pixel reports. Each
// output beat is compared field by field against the oldest prediction, while
// both stream sides are throttled at random in the first two of three phases.
// ----------------------------------------------------------------------------
module sprite_xor_frame_store_top_tb;

    // Screen geometry of the instance and the bench limits.
    localparam int SCR_W        = sxfs_pkg::SCREEN_WIDTH_DEF;
    localparam int SCR_H        = sxfs_pkg::SCREEN_HEIGHT_DEF;
    localparam int PIXELS       = SCR_W * SCR_H;
    localparam int RANDOM_BEATS = 300;
    localparam int STALL_LIMIT  = 4000;

    // Operation codes carried in tuser of the input stream.
    localparam logic OP_DRAW  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // One input beat, unpacked.
    typedef struct packed {
        logic                           op;
        logic [sxfs_pkg::ORIGIN_W-1:0]  ox;
        logic [sxfs_pkg::ORIGIN_W-1:0]  oy;
        logic [sxfs_pkg::ROW_IDX_W-1:0] row;
        logic [sxfs_pkg::SPRITE_W-1:0]  bits;
        logic                           first;
        logic                           last;
    } t_draw_item;

    // One pixel report, unpacked.
    typedef struct packed {
        logic                         pix_valid;
        logic [sxfs_pkg::PIX_X_W-1:0] x;
        logic [sxfs_pkg::PIX_Y_W-1:0] y;
        logic                         value;
        logic                         coll;
        logic                         run_last;
        logic                         done;
    } t_pixel_report;

    // A directed beat, with a literal report where it is obvious.
    typedef struct packed {
        t_draw_item    item;
        logic          has_lit;
        t_pixel_report lit;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // origin_x[7:0], origin_y[15:8], row_index[19:16], sprite_row[27:20],
    // first_row[28], zero[31:29]
    logic [31:0] s_axis_tdata = '0;
    // operation[0]
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // pixel_x[5:0], pixel_y[10:6], pixel_value[11], collision[12],
    // sprite_done[13], zero[15:14]
    logic [15:0] m_axis_tdata;
    // pixel_valid[0]
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // Local copy of the screen and the predicted pixel reports.
    bit            frame_px [0:PIXELS-1];
    bit            sprite_coll = 1'b0;
    t_pixel_report expected_reports [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int beats_sent = 0;
    int clears_sent = 0;
    int reports_seen = 0;
    int sprites_done = 0;
    int sprites_collided = 0;
    int stall_cycles = 0;

    sprite_xor_frame_store_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Directed beats: extremes, clears, empty rows, wrap-around and redraws.
    localparam int DIR_ROWS = 20;
    localparam t_directed_row DIRECTED [DIR_ROWS] = '{
        '{'{OP_DRAW,  8'd0,   8'd0,   4'd0,  8'h80, 1'b1, 1'b1}, 1'b1,
          '{1'b1, 6'd0, 5'd0, 1'b1, 1'b0, 1'b1, 1'b1}},
        '{'{OP_DRAW,  8'd0,   8'd0,   4'd0,  8'h80, 1'b1, 1'b1}, 1'b1,
          '{1'b1, 6'd0, 5'd0, 1'b0, 1'b1, 1'b1, 1'b1}},
        '{'{OP_CLEAR, 8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 1'b0}, 1'b1,
          '{1'b0, 6'd0, 5'd0, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{'{OP_DRAW,  8'd0,   8'd0,   4'd0,  8'h00, 1'b1, 1'b0}, 1'b1,
          '{1'b0, 6'd0, 5'd0, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{'{OP_DRAW,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 1'b1}, 1'b1,
          '{1'b0, 6'd0, 5'd0, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{'{OP_CLEAR, 8'hFF,  8'hFF,  4'hF,  8'hFF, 1'b1, 1'b1}, 1'b1,
          '{1'b0, 6'd0, 5'd0, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{'{OP_DRAW,  8'hFF,  8'hFF,  4'hF,  8'hFF, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_DRAW,  8'hFF,  8'hFF,  4'hF,  8'hFF, 1'b0, 1'b1}, 1'b0, '0},
        '{'{OP_DRAW,  8'd0,   8'd0,   4'd0,  8'h01, 1'b1, 1'b1}, 1'b1,
          '{1'b1, 6'd7, 5'd0, 1'b1, 1'b0, 1'b1, 1'b1}},
        '{'{OP_DRAW,  8'd63,  8'd31,  4'd0,  8'h81, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_DRAW,  8'd40,  8'd200, 4'd15, 8'h55, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_DRAW,  8'd40,  8'd200, 4'd15, 8'hAA, 1'b0, 1'b1}, 1'b0, '0},
        '{'{OP_DRAW,  8'd17,  8'd5,   4'd1,  8'h3C, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_DRAW,  8'd17,  8'd5,   4'd2,  8'h42, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_DRAW,  8'd17,  8'd5,   4'd3,  8'h3C, 1'b0, 1'b1}, 1'b0, '0},
        '{'{OP_DRAW,  8'd17,  8'd5,   4'd3,  8'h3C, 1'b1, 1'b1}, 1'b0, '0},
        '{'{OP_DRAW,  8'd128, 8'd64,  4'd8,  8'hF0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{OP_CLEAR, 8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_DRAW,  8'd0,   8'd0,   4'd0,  8'h80, 1'b1, 1'b0}, 1'b1,
          '{1'b1, 6'd0, 5'd0, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{'{OP_DRAW,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 1'b0}, 1'b1,
          '{1'b0, 6'd0, 5'd0, 1'b0, 1'b0, 1'b1, 1'b0}}
    };

    // Clock with a period of 12.
    always #6 i_clk = ~i_clk;

    // XOR one accepted beat into the local frame and queue its pixel reports.
    task automatic predict_draw(input t_draw_item it);
        int            py;
        int            px;
        int            idx;
        bit            prev;
        t_pixel_report rep;
        if (it.op == OP_CLEAR) begin
            for (int i = 0; i < PIXELS; i++) begin
                frame_px[i] = 1'b0;
            end
            rep = '{1'b0, '0, '0, 1'b0, sprite_coll, 1'b1, 1'b0};
            expected_reports.push_back(rep);
            clears_sent++;
        end else begin
            if (it.first) begin
                sprite_coll = 1'b0;
            end
            if (it.bits == '0) begin
                rep = '{1'b0, '0, '0, 1'b0, sprite_coll, 1'b1, it.last};
                expected_reports.push_back(rep);
            end else begin
                py = (int'(it.oy) + int'(it.row)) % SCR_H;
                // Bit 7 is the leftmost pixel, at the origin column.
                for (int b = 7; b >= 0; b--) begin
                    if (it.bits[b]) begin
                        px = (int'(it.ox) + 7 - b) % SCR_W;
                        idx = py * SCR_W + px;
                        prev = frame_px[idx];
                        frame_px[idx] = ~prev;
                        if (prev) begin
                            sprite_coll = 1'b1;
                        end
                        rep.pix_valid = 1'b1;
                        rep.x         = sxfs_pkg::PIX_X_W'(px);
                        rep.y         = sxfs_pkg::PIX_Y_W'(py);
                        rep.value     = frame_px[idx];
                        rep.coll      = sprite_coll;
                        rep.run_last  = ((it.bits & ((8'd1 << b) - 8'd1)) == '0);
                        rep.done      = rep.run_last & it.last;
                        expected_reports.push_back(rep);
                    end
                end
            end
        end
    endtask

    // Offer one beat on the input stream, after a random gap, until taken.
    task automatic send_beat(input t_draw_item it, input logic has_lit,
                             input t_pixel_report lit);
        bit taken;
        taken = 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, it.first, it.bits, it.row, it.oy, it.ox};
        s_axis_tuser  <= it.op;
        s_axis_tlast  <= it.last;
        while (!taken) begin
            @(posedge i_clk);
            taken = s_axis_tvalid && s_axis_tready;
        end
        predict_draw(it);
        // A directed row with a literal report replaces the predicted one.
        if (has_lit) begin
            expected_reports[expected_reports.size() - 1] = lit;
        end
        beats_sent++;
        @(negedge i_clk);
    endtask

    // Random draw beat; zero rows come up about one time in eight.
    function automatic t_draw_item random_row(input int ox, input int oy, input int row,
                                              input bit first, input bit last);
        t_draw_item it;
        it.op    = OP_DRAW;
        it.ox    = sxfs_pkg::ORIGIN_W'(ox);
        it.oy    = sxfs_pkg::ORIGIN_W'(oy);
        it.row   = sxfs_pkg::ROW_IDX_W'(row);
        it.bits  = ($urandom_range(7) == 0) ? 8'h00
                                            : sxfs_pkg::SPRITE_W'($urandom_range(255, 1));
        it.first = first;
        it.last  = last;
        return it;
    endfunction

    // Set the idle rates of both sides from the progress of the run.
    task automatic set_pressure_phase(input int done_beats);
        if (done_beats < RANDOM_BEATS / 3) begin
            send_idle_pct = 33;
            recv_idle_pct = 48;
        end else if (done_beats < 2 * RANDOM_BEATS / 3) begin
            send_idle_pct = 48;
            recv_idle_pct = 33;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    // Compare one field of a pixel report.
    task automatic check_field(input string fname, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    // Output ready, throttled at the falling edge.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check each output beat and watch for a stalled run.
    always @(posedge i_clk) begin
        t_pixel_report want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                reports_seen++;
                if (m_axis_tdata[13]) begin
                    sprites_done++;
                    sprites_collided += m_axis_tdata[12];
                end
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected pixel report, expected none, %s %h tuser %b tlast %b",
                             $time, "actual tdata", m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("pixel_valid", want.pix_valid, m_axis_tuser);
                    check_field("pixel_x", want.x, m_axis_tdata[5:0]);
                    check_field("pixel_y", want.y, m_axis_tdata[10:6]);
                    check_field("pixel_value", want.value, m_axis_tdata[11]);
                    check_field("collision", want.coll, m_axis_tdata[12]);
                    check_field("run_last", want.run_last, m_axis_tlast);
                    check_field("sprite_done", want.done, m_axis_tdata[13]);
                end
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Reset, directed table, random sprites, drain and verdict.
    initial begin
        t_draw_item it;
        int         height;
        int         ox;
        int         oy;
        int         pick;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_pressure_phase(0);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_beat(DIRECTED[i].item, DIRECTED[i].has_lit, DIRECTED[i].lit);
        end

        // Mostly whole sprites with random content, some clears and noise rows.
        while (beats_sent < DIR_ROWS + RANDOM_BEATS) begin
            set_pressure_phase(beats_sent - DIR_ROWS);
            pick = $urandom_range(99);
            if (pick < 6) begin
                it = '{OP_CLEAR,
                       sxfs_pkg::ORIGIN_W'($urandom), sxfs_pkg::ORIGIN_W'($urandom),
                       sxfs_pkg::ROW_IDX_W'($urandom), sxfs_pkg::SPRITE_W'($urandom),
                       1'($urandom), 1'($urandom)};
                send_beat(it, 1'b0, '0);
            end else if (pick < 18) begin
                it = random_row($urandom_range(255), $urandom_range(255),
                                $urandom_range(15), 1'($urandom), 1'($urandom));
                send_beat(it, 1'b0, '0);
            end else begin
                height = ($urandom_range(9) == 0) ? 15 : $urandom_range(6, 1);
                ox = $urandom_range(255);
                oy = $urandom_range(255);
                for (int r = 0; r < height; r++) begin
                    it = random_row(ox, oy, r, r == 0, r == height - 1);
                    send_beat(it, 1'b0, '0);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then keep watching for stray beats before the verdict.
        while (expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SCR_H + 8) @(posedge i_clk);

        $display("Sent %0d input beats including %0d screen clears, under three throttling phases.",
                 beats_sent, clears_sent);
        $display("Checked %0d pixel reports; %0d sprites finished, %0d of them with collision.",
                 reports_seen, sprites_done, sprites_collided);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/sxfs_pkg.sv
hdl/sxfs_ram.sv
hdl/sxfs_ctrl.sv
hdl/sxfs_dpath.sv
hdl/sprite_xor_frame_store_top.sv
tb/sprite_xor_frame_store_top_tb.sv
